@@ design/spq_pkg.sv @@
// shared types and constants for the severity priority queue
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SERVE   = 2'd1,
    OP_VIEW    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_ADDED  = 3'd0,
    STAT_SERVED = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_VIEW   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_VIEW = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] name;
    logic [7:0]  severity;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    fresh;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/spq_cell.sv @@
// one storage cell of the sorted entry row
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::entry_t   prev_entry,
  input  wire logic              prev_valid,
  input  wire logic              prev_ahead,
  input  wire spq_pkg::entry_t   next_entry,
  input  wire logic              next_valid,
  input  wire spq_pkg::entry_t   head_entry,
  output spq_pkg::entry_t        entry,
  output logic                   valid,
  output logic                   ahead
);

  spq_pkg::entry_t entry_next;
  logic            valid_next;

  // entry ranks ahead of or equal to the incoming one
  assign ahead = valid && ((entry.severity > ctrl.fresh.severity) ||
                 ((entry.severity == ctrl.fresh.severity) &&
                  (entry.arrival <= ctrl.fresh.arrival)));

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    case (ctrl.cmd)
      spq_pkg::CELL_INSERT: begin
        if (!ahead) begin
          if (prev_ahead) begin
            entry_next = ctrl.fresh;
            valid_next = 1'b1;
          end else begin
            entry_next = prev_entry;
            valid_next = prev_valid;
          end
        end
      end
      spq_pkg::CELL_SHIFT: begin
        entry_next = next_entry;
        valid_next = next_valid;
      end
      spq_pkg::CELL_ROTATE: begin
        if (valid) begin
          entry_next = next_valid ? next_entry : head_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

@@ design/severity_priority_queue_core.sv @@
// top level: sorted cell row priority queue with command control
// enqueue and serve: result is registered and shows in the cycle after the transaction, next one may follow at once
// view: the state register moves to view, then results follow, one stored entry per cycle
// view: busy while the stored entries are read out, low again while the last result shows
// empty-queue and full-queue cases give a single result in the cycle after the transaction
// synchronous reset empties the row; results cannot be held off by the receiver
`timescale 1ns / 1ps
`default_nettype none
module severity_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] patient_id,
  input  wire logic [31:0] name_ref,
  input  wire logic [7:0]  severity,
  input  wire logic [31:0] arrival_time,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      out_patient_id,
  output logic [31:0]      out_name_ref,
  output logic [7:0]       out_severity,
  output logic [31:0]      out_arrival_time,
  output logic             last
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_t     state, state_next;
  logic [CW-1:0]       occupancy, occupancy_next;
  logic [CW-1:0]       view_cnt, view_cnt_next;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::cell_cmd_t  cell_cmd;
  logic                accept;

  logic                done_next;
  spq_pkg::status_t    status_reg, status_next;
  spq_pkg::entry_t     res_entry, res_entry_next;
  logic                last_next;

  spq_pkg::entry_t     cell_entry [DEPTH+1];
  logic [DEPTH:0]      cell_valid;
  logic [DEPTH:0]      cell_ahead;
  spq_pkg::entry_t     head;
  logic                empty, full;

  assign head  = cell_entry[1];
  assign empty = !cell_valid[1];
  assign full  = cell_valid[DEPTH];

  // index 0 is the boundary in front of the head
  assign cell_entry[0] = '0;
  assign cell_valid[0] = 1'b0;
  assign cell_ahead[0] = 1'b1;

  assign ctrl.cmd            = cell_cmd;
  assign ctrl.fresh.id       = patient_id;
  assign ctrl.fresh.name     = name_ref;
  assign ctrl.fresh.severity = severity;
  assign ctrl.fresh.arrival  = arrival_time;

  genvar g;
  generate
    for (g = 1; g <= DEPTH; g++) begin : g_cell
      spq_pkg::entry_t nxt_entry;
      logic            nxt_valid;
      if (g == DEPTH) begin : g_tail
        assign nxt_entry = '0;
        assign nxt_valid = 1'b0;
      end else begin : g_mid
        assign nxt_entry = cell_entry[g+1];
        assign nxt_valid = cell_valid[g+1];
      end
      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .prev_entry (cell_entry[g-1]),
        .prev_valid (cell_valid[g-1]),
        .prev_ahead (cell_ahead[g-1]),
        .next_entry (nxt_entry),
        .next_valid (nxt_valid),
        .head_entry (head),
        .entry      (cell_entry[g]),
        .valid      (cell_valid[g]),
        .ahead      (cell_ahead[g])
      );
    end
  endgenerate

  assign busy   = (state == spq_pkg::ST_VIEW);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (accept && (operation == spq_pkg::OP_VIEW) && !empty) begin
          state_next = spq_pkg::ST_VIEW;
        end
      end
      spq_pkg::ST_VIEW: begin
        if (view_cnt == occupancy - CW'(1)) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs and row control
  always_comb begin
    cell_cmd       = spq_pkg::CELL_HOLD;
    occupancy_next = occupancy;
    view_cnt_next  = view_cnt;
    done_next      = 1'b0;
    status_next    = spq_pkg::STAT_ADDED;
    res_entry_next = '0;
    last_next      = 1'b0;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          case (spq_pkg::op_t'(operation))
            spq_pkg::OP_ENQUEUE: begin
              done_next = 1'b1;
              last_next = 1'b1;
              if (full) begin
                status_next = spq_pkg::STAT_FULL;
              end else begin
                cell_cmd       = spq_pkg::CELL_INSERT;
                status_next    = spq_pkg::STAT_ADDED;
                occupancy_next = occupancy + CW'(1);
              end
            end
            spq_pkg::OP_SERVE: begin
              done_next = 1'b1;
              last_next = 1'b1;
              if (empty) begin
                status_next = spq_pkg::STAT_EMPTY;
              end else begin
                cell_cmd       = spq_pkg::CELL_SHIFT;
                status_next    = spq_pkg::STAT_SERVED;
                res_entry_next = head;
                occupancy_next = occupancy - CW'(1);
              end
            end
            spq_pkg::OP_VIEW: begin
              if (empty) begin
                done_next   = 1'b1;
                last_next   = 1'b1;
                status_next = spq_pkg::STAT_EMPTY;
              end else begin
                view_cnt_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::ST_VIEW: begin
        cell_cmd       = spq_pkg::CELL_ROTATE;
        done_next      = 1'b1;
        status_next    = spq_pkg::STAT_VIEW;
        res_entry_next = head;
        last_next      = (view_cnt == occupancy - CW'(1));
        view_cnt_next  = view_cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      occupancy <= '0;
      view_cnt  <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      view_cnt  <= view_cnt_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status_reg <= status_next;
    res_entry  <= res_entry_next;
    last       <= last_next;
  end

  assign status           = status_reg;
  assign out_patient_id   = res_entry.id;
  assign out_name_ref     = res_entry.name;
  assign out_severity     = res_entry.severity;
  assign out_arrival_time = res_entry.arrival;

endmodule
`default_nettype wire
